// ----- design/cset_pkg.sv -----
// ----------------------------------------------------------------------------
// cset_pkg: shared definitions for the call stack exclusive time profiler
// Sizes, request and status codes, and the controller command bundle.
// ----------------------------------------------------------------------------
package cset_pkg;

    // Table and stack sizes
    localparam int NUM_FUNCS   = 256;
    localparam int STACK_DEPTH = 64;

    // Field widths
    localparam int REQ_W  = 2;
    localparam int ID_W   = 8;
    localparam int TIME_W = 32;
    localparam int STAT_W = 2;

    // Derived storage widths
    localparam int FUNC_W = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
    localparam int SP_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_START = 2'd0;
    localparam logic [REQ_W-1:0] REQ_END   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic issue;   // capture request and launch memory reads
        logic commit;  // update state and load result register
    } dp_cmd_t;

endpackage

// ----- design/cset_ctrl.sv -----
// ----------------------------------------------------------------------------
// cset_ctrl: request sequencer
// Two-state controller: take a request, then commit it into the result
// register once that register is free or being drained.
// ----------------------------------------------------------------------------
module cset_ctrl
    import cset_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output dp_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    // Handshake decode
    always_comb begin
        s_tready   = (state_reg == ST_IDLE);
        cmd.issue  = s_tvalid && (state_reg == ST_IDLE);
        cmd.commit = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);
    end

    // Next state and result valid flag
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (cmd.issue) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (cmd.commit) begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ----- design/cset_dp.sv -----
// ----------------------------------------------------------------------------
// cset_dp: profiler datapath
// Call stack (top entry in registers, the rest in a memory), totals memory
// with per-entry valid bits, saturating credit adder and result register.
// ----------------------------------------------------------------------------
module cset_dp
    import cset_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    input  logic [REQ_W-1:0]  req_type,
    input  logic [ID_W-1:0]   func_id,
    input  logic [TIME_W-1:0] timestamp,
    output logic [ID_W-1:0]   result_id,
    output logic [TIME_W-1:0] total_time,
    output logic              credited,
    output logic [STAT_W-1:0] status
);

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Memories; a caller's resume time is rebuilt from the end tick on pop,
    // so only identifiers are kept below the top entry
    logic [TIME_W-1:0] tot_mem [NUM_FUNCS];
    logic [ID_W-1:0]   stk_mem [STACK_DEPTH];

    // State
    logic [NUM_FUNCS-1:0] tot_vld_reg, tot_vld_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ID_W-1:0]      top_id_reg, top_id_next;
    logic [TIME_W-1:0]    top_time_reg, top_time_next;

    // Captured request and read data
    logic [REQ_W-1:0]  req_q;
    logic [ID_W-1:0]   id_q;
    logic [TIME_W-1:0] ts_q;
    logic [TIME_W:0]   delta_q;
    logic [TIME_W-1:0] tot_q;
    logic              tot_vld_q;
    logic [ID_W-1:0]   stk_q;

    // Result register
    logic [ID_W-1:0]   res_id_reg, res_id_next;
    logic [TIME_W-1:0] res_tot_reg, res_tot_next;
    logic              res_cred_reg, res_cred_next;
    logic [STAT_W-1:0] res_stat_reg, res_stat_next;

    // Issue-side address and credit length
    logic [ID_W-1:0]   rd_id;
    logic              rd_in_range;
    logic [TIME_W:0]   ts_ext, t0_ext, delta;

    always_comb begin
        rd_id       = (req_type == REQ_READ) ? func_id : top_id_reg;
        rd_in_range = (int'(rd_id) < NUM_FUNCS);
        ts_ext      = {1'b0, timestamp} + ((req_type == REQ_END) ?
                      {{TIME_W{1'b0}}, 1'b1} : {(TIME_W+1){1'b0}});
        t0_ext      = {1'b0, top_time_reg};
        delta       = (ts_ext > t0_ext) ? (ts_ext - t0_ext) : {(TIME_W+1){1'b0}};
    end

    // Capture request, launch memory reads
    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            req_q     <= req_type;
            id_q      <= func_id;
            ts_q      <= timestamp;
            delta_q   <= delta;
            tot_q     <= tot_mem[rd_id[FUNC_W-1:0]];
            tot_vld_q <= rd_in_range && tot_vld_reg[rd_id[FUNC_W-1:0]];
            stk_q     <= stk_mem[cnt_reg[SP_W-1:0] - SP_W'(2)];
        end
    end

    // Commit-side arithmetic
    logic [TIME_W-1:0] old_tot;
    logic [TIME_W+1:0] sum;
    logic [TIME_W-1:0] new_tot;
    logic              top_in_range;
    logic [TIME_W:0]   end1;
    logic              tot_we, stk_we;

    always_comb begin
        old_tot      = tot_vld_q ? tot_q : {TIME_W{1'b0}};
        sum          = {2'b00, old_tot} + {1'b0, delta_q};
        new_tot      = (sum > {2'b00, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
        top_in_range = (int'(top_id_reg) < NUM_FUNCS);
        end1         = {1'b0, ts_q} + {{TIME_W{1'b0}}, 1'b1};

        cnt_next      = cnt_reg;
        top_id_next   = top_id_reg;
        top_time_next = top_time_reg;
        tot_vld_next  = tot_vld_reg;
        res_id_next   = res_id_reg;
        res_tot_next  = res_tot_reg;
        res_cred_next = res_cred_reg;
        res_stat_next = res_stat_reg;
        tot_we        = 1'b0;
        stk_we        = 1'b0;

        if (cmd.commit) begin
            res_id_next   = {ID_W{1'b0}};
            res_tot_next  = {TIME_W{1'b0}};
            res_cred_next = 1'b0;
            res_stat_next = STAT_OK;
            case (req_q)
                REQ_START: begin
                    if (int'(cnt_reg) >= STACK_DEPTH) begin
                        res_stat_next = STAT_FULL;
                    end else begin
                        // credit the running function and push it down
                        if (cnt_reg != '0) begin
                            res_id_next   = top_id_reg;
                            res_cred_next = 1'b1;
                            res_tot_next  = top_in_range ? new_tot : {TIME_W{1'b0}};
                            tot_we        = top_in_range;
                            stk_we        = 1'b1;
                        end
                        top_id_next   = id_q;
                        top_time_next = ts_q;
                        cnt_next      = cnt_reg + CNT_W'(1);
                    end
                end
                REQ_END: begin
                    if (cnt_reg == '0) begin
                        res_stat_next = STAT_EMPTY;
                    end else begin
                        // credit and pop; the caller resumes the tick after
                        res_id_next   = top_id_reg;
                        res_cred_next = 1'b1;
                        res_tot_next  = top_in_range ? new_tot : {TIME_W{1'b0}};
                        tot_we        = top_in_range;
                        cnt_next      = cnt_reg - CNT_W'(1);
                        if (cnt_reg >= CNT_W'(2)) begin
                            top_id_next   = stk_q;
                            top_time_next = end1[TIME_W] ? TIME_MAX : end1[TIME_W-1:0];
                        end
                    end
                end
                REQ_READ: begin
                    res_id_next  = id_q;
                    res_tot_next = old_tot;
                end
                default: ;
            endcase
            if (tot_we) begin
                tot_vld_next[top_id_reg[FUNC_W-1:0]] = 1'b1;
            end
        end
    end

    // Memory writes
    always_ff @(posedge aclk) begin
        if (tot_we) begin
            tot_mem[top_id_reg[FUNC_W-1:0]] <= new_tot;
        end
        if (stk_we) begin
            stk_mem[cnt_reg[SP_W-1:0] - SP_W'(1)] <= top_id_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tot_vld_reg <= '0;
            cnt_reg     <= '0;
        end else begin
            tot_vld_reg <= tot_vld_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        top_id_reg   <= top_id_next;
        top_time_reg <= top_time_next;
        res_id_reg   <= res_id_next;
        res_tot_reg  <= res_tot_next;
        res_cred_reg <= res_cred_next;
        res_stat_reg <= res_stat_next;
    end

    assign result_id  = res_id_reg;
    assign total_time = res_tot_reg;
    assign credited   = res_cred_reg;
    assign status     = res_stat_reg;

endmodule

// ----- design/call_stack_exclusive_time_top.sv -----
// ----------------------------------------------------------------------------
// call_stack_exclusive_time_top: exclusive run time profiler
// Tracks a call stack from start and end events and keeps per-function
// saturating totals of exclusive time; answers total read requests.
// ----------------------------------------------------------------------------
// A request is first captured while the totals and stack memories are read;
// then the credit is added and written back once the output register is free
// or being drained. A new request is taken while the previous result still
// waits on the output register. One result transfer follows every request
// transfer. Totals start at zero after reset through per-entry valid bits,
// so no clearing pass is needed.
module call_stack_exclusive_time_top
    import cset_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] func_id, [39:8] timestamp
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] result_id, [39:8] total_time
    output logic [2:0]  m_tuser    // [0] credited, [2:1] status
);

    dp_cmd_t           cmd;
    logic [ID_W-1:0]   result_id;
    logic [TIME_W-1:0] total_time;
    logic              credited;
    logic [STAT_W-1:0] status;

    cset_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    cset_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .req_type   (s_tuser[REQ_W-1:0]),
        .func_id    (s_tdata[ID_W-1:0]),
        .timestamp  (s_tdata[ID_W+TIME_W-1:ID_W]),
        .result_id  (result_id),
        .total_time (total_time),
        .credited   (credited),
        .status     (status)
    );

    assign m_tdata = {total_time, result_id};
    assign m_tuser = {status, credited};

endmodule

// ----- verif/exclusive_time_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// exclusive_time_checker: result checker for the exclusive time profiler
// Watches the request and result streams. Every request transfer updates a
// private call stack and totals table and queues the one result it must
// produce. Every result transfer is compared field by field with the oldest
// queued result.
// ----------------------------------------------------------------------------
module exclusive_time_checker
    import cset_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // request channel, observed
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] func_id, [39:8] timestamp
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // result channel, observed
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [7:0] result_id, [39:8] total_time
    input  logic [2:0]  m_tuser,   // [0] credited, [2:1] status
    // to the testbench top
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          full_drops,
    output int          empty_drops,
    output int          saturations
);

    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] total;
        logic              credited;
        logic [STAT_W-1:0] status;
    } profile_result_t;

    // Shadow of the profiler state
    logic [ID_W-1:0]   call_ids  [STACK_DEPTH];
    logic [TIME_W-1:0] resume_at [STACK_DEPTH];
    int unsigned       call_depth;
    logic [TIME_W-1:0] func_total [NUM_FUNCS];

    // Results still owed by the block, oldest first
    profile_result_t   expected_results [$];

    // One line per mismatch, printing capped to keep the log short
    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_failure($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    // Saturating add to a function's total; returns the new total
    function automatic logic [TIME_W-1:0] add_credit(input logic [ID_W-1:0] fid,
                                                     input logic [TIME_W:0] delta);
        logic [TIME_W+1:0] sum;
        if (int'(fid) >= NUM_FUNCS) begin
            return '0;
        end
        sum = {2'b00, func_total[fid]} + {1'b0, delta};
        if (sum > {2'b00, {TIME_W{1'b1}}}) begin
            sum = {2'b00, {TIME_W{1'b1}}};
            saturations++;
        end
        func_total[fid] = sum[TIME_W-1:0];
        return func_total[fid];
    endfunction

    // Apply one request to the shadow state and give the result it causes
    function automatic profile_result_t predict_exclusive_time(
        input logic [REQ_W-1:0] req, input logic [ID_W-1:0] fid,
        input logic [TIME_W-1:0] ts);
        profile_result_t r;
        int unsigned     top;
        logic [TIME_W:0] end_tick;
        logic [TIME_W:0] delta;
        r = '0;
        case (req)
            REQ_START: begin
                if (call_depth >= STACK_DEPTH) begin
                    r.status = STAT_FULL;
                    full_drops++;
                end else begin
                    // credit the caller up to now, it resumes when the callee ends
                    if (call_depth > 0) begin
                        top = call_depth - 1;
                        delta = (ts > resume_at[top]) ? {1'b0, ts - resume_at[top]} : '0;
                        r.id = call_ids[top];
                        r.total = add_credit(r.id, delta);
                        r.credited = 1'b1;
                        resume_at[top] = ts;
                    end
                    call_ids[call_depth] = fid;
                    resume_at[call_depth] = ts;
                    call_depth++;
                end
            end
            REQ_END: begin
                if (call_depth == 0) begin
                    r.status = STAT_EMPTY;
                    empty_drops++;
                end else begin
                    // end tick counts for the callee, caller resumes one tick later
                    top = call_depth - 1;
                    end_tick = {1'b0, ts} + 1'b1;
                    delta = (end_tick > {1'b0, resume_at[top]}) ?
                            end_tick - {1'b0, resume_at[top]} : '0;
                    r.id = call_ids[top];
                    r.total = add_credit(r.id, delta);
                    r.credited = 1'b1;
                    call_depth = top;
                    if (top > 0) begin
                        resume_at[top-1] = end_tick[TIME_W] ? {TIME_W{1'b1}} :
                                                              end_tick[TIME_W-1:0];
                    end
                end
            end
            REQ_READ: begin
                r.id = fid;
                r.total = (int'(fid) < NUM_FUNCS) ? func_total[fid] : '0;
            end
            default: begin
                // unused request code: all-zero result
            end
        endcase
        return r;
    endfunction

    // Sample both channels at the clock edge
    always @(posedge aclk) begin
        profile_result_t got;
        profile_result_t want;
        if (!aresetn) begin
            call_depth = 0;
            foreach (func_total[i]) func_total[i] = '0;
            expected_results.delete();
        end else begin
            // result transfer first: it can only answer an earlier request
            if (m_tvalid && m_tready) begin
                got.id       = m_tdata[ID_W-1:0];
                got.total    = m_tdata[ID_W +: TIME_W];
                got.credited = m_tuser[0];
                got.status   = m_tuser[2:1];
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_failure($sformatf("result with no request pending: id %0d total %0d",
                                             got.id, got.total));
                end else begin
                    want = expected_results.pop_front();
                    check_field("result_id", 32'(got.id), 32'(want.id));
                    check_field("total_time", got.total, want.total);
                    check_field("credited", 32'(got.credited), 32'(want.credited));
                    check_field("status", 32'(got.status), 32'(want.status));
                end
            end
            // request transfer
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_exclusive_time(
                    s_tuser, s_tdata[ID_W-1:0], s_tdata[ID_W +: TIME_W]));
            end
        end
        pending = expected_results.size();
    end

endmodule

// ----- verif/call_stack_exclusive_time_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// call_stack_exclusive_time_top_tb: testbench for the exclusive time profiler
// Drives a short directed trace through the empty, clamp and saturation corners,
// then random call traces, which also hit the full corner: mostly well-nested start/end sequences
// with rising timestamps, plus reads and noise. Both stream sides idle at
// random and the result side holds off once for a long stretch. A separate
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module call_stack_exclusive_time_top_tb;
    import cset_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int LIMIT_CYCLES  = 600000;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int TAIL_CYCLES   = 16;
    localparam int ID_POOL       = 8;

    typedef enum int {EP_FILL, EP_DRAIN, EP_CLIMB, EP_FALL, EP_MIX, EP_NOISE} episode_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // [7:0] func_id, [39:8] timestamp
    logic [1:0]  s_tuser;    // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // [7:0] result_id, [39:8] total_time
    logic [2:0]  m_tuser;    // [0] credited, [2:1] status

    int fail_count;
    int pending;
    int results_seen;
    int full_drops;
    int empty_drops;
    int saturations;

    int cycle_count = 0;
    int n_start = 0;
    int n_end = 0;
    int n_read = 0;
    int n_unused = 0;
    int trace_depth = 0;
    logic [TIME_W-1:0] trace_now = '0;
    bit send_steady = 1'b0;
    bit recv_steady = 1'b0;

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    call_stack_exclusive_time_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    exclusive_time_checker time_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .full_drops   (full_drops),
        .empty_drops  (empty_drops),
        .saturations  (saturations)
    );

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("FAIL");
            $finish;
        end
    end

    // Idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Advance the trace time: small steps, repeats, rare big jumps;
    // near the top of the range it sometimes restarts low
    function automatic logic [TIME_W-1:0] advance_clock();
        logic [TIME_W:0] sum;
        int r;
        r = $urandom_range(0, 99);
        if (trace_now >= 32'hF000_0000 && $urandom_range(0, 15) == 0) begin
            trace_now = $urandom_range(0, 1023);
            return trace_now;
        end
        if (r < 60) sum = {1'b0, trace_now} + $urandom_range(0, 8);
        else if (r < 85) sum = {1'b0, trace_now} + $urandom_range(9, 200);
        else if (r < 95) sum = {1'b0, trace_now};
        else sum = {1'b0, trace_now} + $urandom_range(32'h0010_0000, 32'h8000_0000);
        trace_now = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
        return trace_now;
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 3) != 0) return ID_W'($urandom_range(0, ID_POOL - 1));
        return ID_W'($urandom_range(0, 255));
    endfunction

    // One request transfer, then an optional idle gap
    task automatic send_item(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] fid,
                             input logic [TIME_W-1:0] ts);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {ts, fid};
        do @(posedge aclk); while (!s_tready);
        case (req)
            REQ_START: begin
                n_start++;
                if (trace_depth < STACK_DEPTH) trace_depth++;
            end
            REQ_END: begin
                n_end++;
                if (trace_depth > 0) trace_depth--;
            end
            REQ_READ: n_read++;
            default:  n_unused++;
        endcase
        gap = send_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Result side: random ready windows and stalls, one long hold-off
    initial begin
        int stall;
        bit held;
        held = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!held && results_seen >= HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
                if ($urandom_range(0, 19) == 0) recv_steady = !recv_steady;
                stall = recv_steady ? 0 : pick_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int counted;
        int ep;
        int len;
        int r;
        episode_t kind;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= REQ_START;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty stack, reads of untouched totals, unused code,
        // nested credit, clamped credit, resume tick overflow, saturation
        send_item(REQ_END,    8'h00, 32'h0000_0000);
        send_item(REQ_READ,   8'h00, 32'h0000_0000);
        send_item(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF);
        send_item(REQ_START,  8'h00, 32'd10);
        send_item(REQ_START,  8'hFF, 32'd15);
        send_item(REQ_START,  8'h80, 32'd12);
        send_item(REQ_END,    8'h00, 32'd20);
        send_item(REQ_END,    8'h00, 32'hFFFF_FFFE);
        send_item(REQ_START,  8'h01, 32'hFFFF_FFFF);
        send_item(REQ_END,    8'h00, 32'hFFFF_FFFF);
        send_item(REQ_END,    8'h00, 32'hFFFF_FFFF);
        send_item(REQ_START,  8'h02, 32'h0000_0000);
        send_item(REQ_END,    8'h55, 32'hFFFF_FFFF);
        send_item(REQ_READ,   8'h02, 32'h0000_0000);
        send_item(REQ_READ,   8'hFF, 32'h0000_0000);
        send_item(REQ_READ,   8'hAA, 32'hAAAA_5555);
        send_item(REQ_END,    8'h00, 32'h0000_0000);
        trace_now = '0;

        // Random traces in episodes; fill and drain come around regularly
        counted = 0;
        ep = 0;
        while (counted < RANDOM_ITEMS) begin
            if (ep % 6 == 0) kind = EP_FILL;
            else if (ep % 6 == 3) kind = EP_DRAIN;
            else kind = episode_t'($urandom_range(EP_CLIMB, EP_NOISE));
            send_steady = ($urandom_range(0, 3) == 0);
            ep++;
            case (kind)
                EP_FILL: begin
                    while (trace_depth < STACK_DEPTH) begin
                        send_item(REQ_START, pick_id(), advance_clock());
                        counted++;
                    end
                    // pushes onto a full stack
                    repeat ($urandom_range(1, 3)) begin
                        send_item(REQ_START, pick_id(), advance_clock());
                        counted++;
                    end
                end
                EP_DRAIN: begin
                    while (trace_depth > 0) begin
                        send_item(REQ_END, pick_id(), advance_clock());
                        counted++;
                    end
                    // ends on an empty stack
                    repeat ($urandom_range(1, 3)) begin
                        send_item(REQ_END, pick_id(), advance_clock());
                        counted++;
                    end
                    for (int i = 0; i < ID_POOL; i++) begin
                        send_item(REQ_READ, ID_W'(i), advance_clock());
                        counted++;
                    end
                end
                EP_NOISE: begin
                    len = $urandom_range(10, 30);
                    repeat (len) begin
                        r = $urandom_range(0, 3);
                        send_item(REQ_W'(r), ID_W'($urandom_range(0, 255)), $urandom());
                        if (r != REQ_UNUSED) counted++;
                    end
                end
                default: begin
                    // biased walk: climb favors starts, fall favors ends
                    len = $urandom_range(20, 60);
                    repeat (len) begin
                        r = $urandom_range(0, 99);
                        if (kind == EP_CLIMB) r = (r < 65) ? 0 : (r < 85) ? 1 : 2;
                        else if (kind == EP_FALL) r = (r < 25) ? 0 : (r < 85) ? 1 : 2;
                        else r = (r < 40) ? 0 : (r < 80) ? 1 : 2;
                        case (r)
                            0:       send_item(REQ_START, pick_id(), advance_clock());
                            1:       send_item(REQ_END, pick_id(), advance_clock());
                            default: send_item(REQ_READ, pick_id(), advance_clock());
                        endcase
                        counted++;
                    end
                end
            endcase
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then a short quiet tail
        while (pending != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Requests: %0d start, %0d end, %0d read, %0d unused code; %0d results checked",
                 n_start, n_end, n_read, n_unused, results_seen);
        $display("Corners hit: %0d full-stack drops, %0d empty-stack ends, %0d saturated totals",
                 full_drops, empty_drops, saturations);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
